FILE: hdl/video_wall_grid_layout_unit_assert.svh
// Assertion macros shared by the video wall grid layout unit.
`ifndef VIDEO_WALL_GRID_LAYOUT_UNIT_ASSERT_SVH
`define VIDEO_WALL_GRID_LAYOUT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vwg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vwg assertion failed");

`endif

FILE: hdl/vwg_pkg.sv
// Types and constants shared by the video wall grid layout unit.
package vwg_pkg;

  localparam int DIM_W         = 12;
  localparam int CNT_W         = 7;
  localparam int IDX_W         = 6;
  localparam int ROOT_W        = 4;
  localparam int CFG_ADDR_W    = 1;
  localparam int DEF_MAX_CELLS = 64;
  localparam int RESULT_LIMIT  = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [DIM_W-1:0] DEF_DISPLAY_WIDTH  = 12'd1920;
  localparam logic [DIM_W-1:0] DEF_DISPLAY_HEIGHT = 12'd1080;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_GRID  = 2'd2
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DISPLAY_WIDTH  = 1'b0,
    REG_DISPLAY_HEIGHT = 1'b1
  } cfg_reg_e;

  // Display geometry as held in the configuration registers.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } disp_t;

  // Classified request handed from the front end to the emitter.
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } cmd_t;

endpackage

FILE: hdl/vwg_if.sv
// Handshake interfaces for layout requests, cell rectangles and configuration writes.
interface vwg_req_if import vwg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [CNT_W-1:0] stream_count;
  logic [CNT_W-1:0] grid_rows;
  logic [CNT_W-1:0] grid_cols;

  modport source (output valid, mode, stream_count, grid_rows, grid_cols, input ready);
  modport sink   (input valid, mode, stream_count, grid_rows, grid_cols, output ready);
endinterface

interface vwg_cell_if import vwg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;
  logic [DIM_W-1:0] x;
  logic [DIM_W-1:0] y;
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, cell_index, x, y, width, height, status, last,
                  input ready);
  modport sink   (input valid, cell_index, x, y, width, height, status, last,
                  output ready);
endinterface

interface vwg_cfg_if import vwg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [DIM_W-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: hdl/video_wall_grid_layout_unit.sv
// Top level of the video wall grid layout unit.
// A request is taken in one beat when the front end is idle. Custom requests and
// bad counts are classified in that cycle; an automatic request first finds the integer
// square root and then evaluates each candidate column in turn, with the 8-step
// divider forming the row count. A two-entry queue lets the next request be
// classified while the emitter works. The emitter performs two 12-step divisions
// of the display size by the column and row counts, then delivers one rectangle
// per cycle while the sink keeps ready high. Errors give one beat with last set
// and all geometry zero. Display registers are written through the configuration
// channel, which is always ready, and should only change while no request is in
// flight.
module video_wall_grid_layout_unit import vwg_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS,
  parameter int Q_DEPTH   = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vwg_req_if.sink    req_if,
  vwg_cfg_if.sink    cfg_if,
  vwg_cell_if.source cell_if
);

`include "video_wall_grid_layout_unit_assert.svh"

  disp_t disp_q;
  logic  front_valid;
  logic  front_ready;
  cmd_t  front_cmd;
  logic  back_valid;
  logic  back_ready;
  cmd_t  back_cmd;
  logic  err_beat;
  logic  geom_zero;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q.width  <= DEF_DISPLAY_WIDTH;
      disp_q.height <= DEF_DISPLAY_HEIGHT;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_reg_e'(cfg_if.addr))
        REG_DISPLAY_WIDTH:  disp_q.width  <= cfg_if.data;
        REG_DISPLAY_HEIGHT: disp_q.height <= cfg_if.data;
        default: ;
      endcase
    end
  end

  vwg_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_if),
    .disp_i      (disp_q),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  vwg_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  vwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .disp_i      (disp_q),
    .rect        (cell_if)
  );

  assign err_beat  = cell_if.valid && (cell_if.status != ST_OK);
  assign geom_zero = (cell_if.width == '0) && (cell_if.height == '0) &&
                     (cell_if.cell_index == '0);

  // An error beat is always the only beat of its request.
  `VWG_ASSERT_NOW(a_err_is_last, clk_i, rst_ni, err_beat, cell_if.last)
  // An error beat carries no geometry.
  `VWG_ASSERT_NOW(a_err_zero, clk_i, rst_ni, err_beat, geom_zero)
  // A command pushed into an empty queue is visible to the emitter next cycle.
  `VWG_ASSERT_NEXT(a_queue_fill, clk_i, rst_ni, front_valid && front_ready && !back_valid, back_valid)

endmodule

FILE: hdl/vwg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module vwg_div import vwg_pkg::*; #(
  parameter int NUM_W = DIM_W,
  parameter int DEN_W = CNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      step_q <= STEP_W'(NUM_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
      quo_q  <= {quo_q[NUM_W-2:0], fits};
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/vwg_front.sv
// Request front end: validates requests and searches the automatic grid shape.
module vwg_front import vwg_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  vwg_req_if.sink        req,
  input  disp_t          disp_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output cmd_t           cmd_o
);

  localparam int DIV_NUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQRT,
    F_CHECK,
    F_DIV,
    F_EVAL,
    F_PUSH
  } fstate_e;

  fstate_e             state_q;
  cmd_t                cmd_q;
  logic [CNT_W-1:0]    n_q;
  logic                land_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CNT_W-1:0]    col_q;
  logic [CNT_W-1:0]    row_q;
  logic [CNT_W-1:0]    sel_rows_q;
  logic [CNT_W-1:0]    sel_cols_q;
  logic [CNT_W-1:0]    min_empty_q;

  logic                accept;
  logic                bad_count;
  logic                bad_grid;
  logic [2*CNT_W-1:0]  grid_size;
  logic [ROOT_W-1:0]   root_next;
  logic [2*ROOT_W-1:0] root_sq;
  logic                col_in_range;
  logic                div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic                div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [CNT_W-1:0]    div_rem;
  logic [2*CNT_W-1:0]  cand_size;
  logic [2*CNT_W-1:0]  cand_empty;
  logic [CNT_W-1:0]    cand_diff;
  logic                cand_take;

  assign req.ready = (state_q == F_IDLE);
  assign accept    = req.valid && req.ready;

  assign bad_count = (req.stream_count == '0) || (32'(req.stream_count) > MAX_CELLS) ||
                     (32'(req.stream_count) > RESULT_LIMIT);
  assign grid_size = (2*CNT_W)'(req.grid_rows) * (2*CNT_W)'(req.grid_cols);
  assign bad_grid  = (req.grid_rows == '0) || (req.grid_cols == '0) ||
                     (grid_size < (2*CNT_W)'(req.stream_count));

  assign root_next = root_q + ROOT_W'(1);
  assign root_sq   = (2*ROOT_W)'(root_next) * (2*ROOT_W)'(root_next);

  // The column bound follows the best row count as it is updated.
  assign col_in_range = {1'b0, col_q} <= ({1'b0, sel_rows_q} + (CNT_W+1)'(2));
  assign div_start    = (state_q == F_CHECK) && col_in_range;
  assign div_num      = {1'b0, n_q} + {1'b0, col_q} - DIV_NUM_W'(1);

  vwg_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (col_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign cand_size  = (2*CNT_W)'(row_q) * (2*CNT_W)'(col_q);
  assign cand_empty = cand_size - (2*CNT_W)'(n_q);
  assign cand_diff  = (row_q > col_q) ? (row_q - col_q) : (col_q - row_q);
  assign cand_take  = (cand_size >= (2*CNT_W)'(n_q)) &&
                      (cand_empty <= (2*CNT_W)'(min_empty_q)) && (cand_diff <= CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      cmd_q       <= '0;
      n_q         <= '0;
      land_q      <= 1'b0;
      root_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      sel_rows_q  <= '0;
      sel_cols_q  <= '0;
      min_empty_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            n_q    <= req.stream_count;
            land_q <= (disp_i.width >= disp_i.height) && (disp_i.width != '0);
            root_q <= '0;
            if (bad_count) begin
              cmd_q   <= '{status: ST_BAD_COUNT, count: '0, rows: '0, cols: '0};
              state_q <= F_PUSH;
            end else if (req.mode) begin
              if (bad_grid) begin
                cmd_q <= '{status: ST_BAD_GRID, count: '0, rows: '0, cols: '0};
              end else begin
                cmd_q <= '{status: ST_OK, count: req.stream_count,
                           rows: req.grid_rows, cols: req.grid_cols};
              end
              state_q <= F_PUSH;
            end else begin
              state_q <= F_SQRT;
            end
          end
        end
        F_SQRT: begin
          if ((2*ROOT_W)'(root_sq) <= (2*ROOT_W)'(n_q)) begin
            root_q <= root_next;
          end else begin
            sel_rows_q  <= CNT_W'(root_q);
            sel_cols_q  <= '0;
            col_q       <= CNT_W'(root_q);
            min_empty_q <= n_q;
            state_q     <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (col_in_range) begin
            state_q <= F_DIV;
          end else begin
            if ((sel_rows_q == '0) || (sel_cols_q == '0)) begin
              cmd_q <= '{status: ST_BAD_COUNT, count: '0, rows: '0, cols: '0};
            end else begin
              cmd_q <= '{status: ST_OK, count: n_q, rows: sel_rows_q, cols: sel_cols_q};
            end
            state_q <= F_PUSH;
          end
        end
        F_DIV: begin
          if (div_done) begin
            row_q   <= div_quo[CNT_W-1:0];
            state_q <= F_EVAL;
          end
        end
        F_EVAL: begin
          if (cand_take) begin
            if (land_q) begin
              sel_rows_q <= row_q;
              sel_cols_q <= col_q;
            end else begin
              sel_rows_q <= col_q;
              sel_cols_q <= row_q;
            end
            min_empty_q <= cand_empty[CNT_W-1:0];
          end
          col_q   <= col_q + CNT_W'(1);
          state_q <= F_CHECK;
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

endmodule

FILE: hdl/vwg_fifo.sv
// Small command queue between the front end and the rectangle emitter.
module vwg_fifo import vwg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cmd_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_QW-1:0] fill_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (fill_q != CNT_QW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + CNT_QW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - CNT_QW'(1);
      end
    end
  end

endmodule

FILE: hdl/vwg_back.sv
// Rectangle emitter: divides the display among the grid and walks the cells.
module vwg_back import vwg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  input  disp_t     disp_i,
  vwg_cell_if.source rect
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIVW,
    B_DIVH,
    B_EMIT,
    B_ERR
  } bstate_e;

  bstate_e           state_q;
  cmd_t              cmd_q;
  logic [DIM_W-1:0]  cw_q;
  logic [CNT_W-1:0]  wr_q;
  logic [DIM_W-1:0]  ch_q;
  logic [CNT_W-1:0]  hr_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  col_q;
  logic [CNT_W-1:0]  row_q;
  logic [DIM_W-1:0]  x_q;
  logic [DIM_W-1:0]  y_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIM_W-1:0]  out_x_q;
  logic [DIM_W-1:0]  out_y_q;
  logic [DIM_W-1:0]  out_w_q;
  logic [DIM_W-1:0]  out_h_q;
  status_e           out_status_q;
  logic              out_last_q;

  logic              take;
  logic              gen;
  logic              div_start;
  logic [DIM_W-1:0]  div_num;
  logic [CNT_W-1:0]  div_den;
  logic              div_done;
  logic [DIM_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_rem;
  logic [DIM_W-1:0]  cell_w;
  logic [DIM_W-1:0]  cell_h;
  logic              cell_last;
  logic              row_end;

  assign cmd_ready_o = (state_q == B_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;

  // The output register refills in the cycle its beat is taken.
  assign gen = ((state_q == B_EMIT) || (state_q == B_ERR)) && (!out_valid_q || rect.ready);

  assign div_start = (take && (cmd_i.status == ST_OK)) || ((state_q == B_DIVW) && div_done);
  assign div_num   = (state_q == B_IDLE) ? disp_i.width : disp_i.height;
  assign div_den   = (state_q == B_IDLE) ? cmd_i.cols : cmd_q.rows;

  vwg_div #(
    .NUM_W (DIM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign cell_w    = cw_q + DIM_W'(col_q < wr_q);
  assign cell_h    = ch_q + DIM_W'(row_q < hr_q);
  assign cell_last = (idx_q + CNT_W'(1)) == cmd_q.count;
  assign row_end   = (col_q + CNT_W'(1)) == cmd_q.cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      cmd_q        <= '0;
      cw_q         <= '0;
      wr_q         <= '0;
      ch_q         <= '0;
      hr_q         <= '0;
      idx_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      x_q          <= '0;
      y_q          <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_w_q      <= '0;
      out_h_q      <= '0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      if (gen) begin
        out_valid_q <= 1'b1;
      end else if (rect.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        B_IDLE: begin
          if (take) begin
            cmd_q   <= cmd_i;
            state_q <= (cmd_i.status == ST_OK) ? B_DIVW : B_ERR;
          end
        end
        B_DIVW: begin
          if (div_done) begin
            cw_q    <= div_quo;
            wr_q    <= div_rem;
            state_q <= B_DIVH;
          end
        end
        B_DIVH: begin
          if (div_done) begin
            ch_q    <= div_quo;
            hr_q    <= div_rem;
            idx_q   <= '0;
            col_q   <= '0;
            row_q   <= '0;
            x_q     <= '0;
            y_q     <= '0;
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (gen) begin
            out_idx_q    <= idx_q[IDX_W-1:0];
            out_x_q      <= x_q;
            out_y_q      <= y_q;
            out_w_q      <= cell_w;
            out_h_q      <= cell_h;
            out_status_q <= ST_OK;
            out_last_q   <= cell_last;
            idx_q        <= idx_q + CNT_W'(1);
            if (row_end) begin
              col_q <= '0;
              row_q <= row_q + CNT_W'(1);
              x_q   <= '0;
              y_q   <= y_q + cell_h;
            end else begin
              col_q <= col_q + CNT_W'(1);
              x_q   <= x_q + cell_w;
            end
            if (cell_last) begin
              state_q <= B_IDLE;
            end
          end
        end
        B_ERR: begin
          if (gen) begin
            out_idx_q    <= '0;
            out_x_q      <= '0;
            out_y_q      <= '0;
            out_w_q      <= '0;
            out_h_q      <= '0;
            out_status_q <= cmd_q.status;
            out_last_q   <= 1'b1;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign rect.valid      = out_valid_q;
  assign rect.cell_index = out_idx_q;
  assign rect.x          = out_x_q;
  assign rect.y          = out_y_q;
  assign rect.width      = out_w_q;
  assign rect.height     = out_h_q;
  assign rect.status     = out_status_q;
  assign rect.last       = out_last_q;

endmodule

FILE: tb/video_wall_grid_layout_unit_test.sv
// Self-checking testbench for the video wall grid layout unit.
`timescale 1ns / 100ps

module video_wall_grid_layout_unit_test import vwg_pkg::*; ();

  localparam int MAX_CELLS    = DEF_MAX_CELLS;
  localparam int SETTLE_CYCLES = 64;
  localparam int TIMEOUT_NS   = 20_000_000;
  localparam int PHASE_ITEMS  = 36;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    status_e          status;
    logic             last;
  } cell_rect_t;

  logic clk;
  logic rst_n;

  vwg_req_if  req_bus ();
  vwg_cfg_if  cfg_bus ();
  vwg_cell_if cell_bus ();

  video_wall_grid_layout_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_if  (req_bus),
    .cfg_if  (cfg_bus),
    .cell_if (cell_bus)
  );

  logic [DIM_W-1:0] layout_w;
  logic [DIM_W-1:0] layout_h;
  cell_rect_t       cells_due[$];
  int               mismatches;
  int               beats_seen;
  int               hold_left;
  int               burst_left;
  bit               steady_send;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Receiver: changes its stall style now and then; a hold-off overrides it.
  initial begin
    int style;
    int style_left;
    int phase;
    style = 0;
    style_left = 0;
    phase = 0;
    cell_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        cell_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(32, 256);
        end
        style_left--;
        phase++;
        case (style)
          0: cell_bus.ready <= 1'b1;
          1: cell_bus.ready <= 1'($urandom_range(0, 1));
          2: cell_bus.ready <= ($urandom_range(0, 3) == 0);
          default: cell_bus.ready <= ((phase % 5) >= 2);
        endcase
      end
    end
  end

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_seen, field, got, want);
  endtask

  // Outputs are sampled at the falling edge, before the rising edge at which the beat is taken.
  always @(negedge clk) begin : check_cells
    cell_rect_t seen;
    cell_rect_t due;
    if (rst_n && cell_bus.valid && cell_bus.ready) begin
      seen.cell_index = cell_bus.cell_index;
      seen.x          = cell_bus.x;
      seen.y          = cell_bus.y;
      seen.width      = cell_bus.width;
      seen.height     = cell_bus.height;
      seen.status     = status_e'(cell_bus.status);
      seen.last       = cell_bus.last;
      if (cells_due.size() == 0) begin
        report_mismatch("beat with nothing pending, cell_index", seen.cell_index, 0);
      end else begin
        due = cells_due.pop_front();
        if (seen.cell_index !== due.cell_index)
          report_mismatch("cell_index", seen.cell_index, due.cell_index);
        if (seen.x !== due.x) report_mismatch("x", seen.x, due.x);
        if (seen.y !== due.y) report_mismatch("y", seen.y, due.y);
        if (seen.width !== due.width) report_mismatch("width", seen.width, due.width);
        if (seen.height !== due.height) report_mismatch("height", seen.height, due.height);
        if (seen.status !== due.status) report_mismatch("status", seen.status, due.status);
        if (seen.last !== due.last) report_mismatch("last", seen.last, due.last);
      end
      beats_seen++;
    end
  end

  function automatic void push_fault(status_e st);
    cell_rect_t rect;
    rect = '0;
    rect.status = st;
    rect.last = 1'b1;
    cells_due.insert(cells_due.size(), rect);
  endfunction

  // Leftover pixels go to the leading columns and rows, one each.
  function automatic void push_grid(int n, int rows, int cols);
    cell_rect_t rect;
    int cw, ch, wr, hr, r, c;
    cw = int'(layout_w) / cols;
    ch = int'(layout_h) / rows;
    wr = int'(layout_w) % cols;
    hr = int'(layout_h) % rows;
    for (int i = 0; i < n; i++) begin
      r = i / cols;
      c = i % cols;
      rect.cell_index = IDX_W'(i);
      rect.width      = DIM_W'(cw + ((c < wr) ? 1 : 0));
      rect.height     = DIM_W'(ch + ((r < hr) ? 1 : 0));
      rect.x          = DIM_W'(c * cw + ((c < wr) ? c : wr));
      rect.y          = DIM_W'(r * ch + ((r < hr) ? r : hr));
      rect.status     = ST_OK;
      rect.last       = (i == n - 1);
      cells_due.insert(cells_due.size(), rect);
    end
  endfunction

  function automatic void plan_layout(logic mode, logic [CNT_W-1:0] count,
                                      logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    int n, nr, nc, root, sel_rows, sel_cols, min_empty, row, empty, diff;
    bit landscape;
    n  = int'(count);
    nr = int'(rows);
    nc = int'(cols);
    if (n == 0 || n > MAX_CELLS || n > RESULT_LIMIT) begin
      push_fault(ST_BAD_COUNT);
    end else if (mode) begin
      if (nr == 0 || nc == 0 || nr * nc < n) begin
        push_fault(ST_BAD_GRID);
      end else begin
        push_grid(n, nr, nc);
      end
    end else begin
      landscape = (layout_w >= layout_h) && (layout_w != 0);
      root = 0;
      while ((root + 1) * (root + 1) <= n) root++;
      sel_rows = root;
      sel_cols = 0;
      min_empty = n;
      // The upper bound follows sel_rows as it changes inside the loop.
      for (int col = sel_rows; col <= sel_rows + 2; col++) begin
        if (col != 0) begin
          row = (n + col - 1) / col;
          empty = row * col - n;
          diff = (row > col) ? row - col : col - row;
          if (empty <= min_empty && diff <= 1) begin
            sel_rows = landscape ? row : col;
            sel_cols = landscape ? col : row;
            min_empty = empty;
          end
        end
      end
      if (sel_rows == 0 || sel_cols == 0) begin
        push_fault(ST_BAD_COUNT);
      end else begin
        push_grid(n, sel_rows, sel_cols);
      end
    end
  endfunction

  // Called and returns at a rising edge; valid is left high for a back-to-back beat.
  task automatic send_request(logic mode, logic [CNT_W-1:0] count,
                              logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    int gap;
    bit taken;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= mode;
    req_bus.stream_count <= count;
    req_bus.grid_rows    <= rows;
    req_bus.grid_cols    <= cols;
    do begin
      @(negedge clk);
      taken = req_bus.ready;
      @(posedge clk);
    end while (!taken);
    plan_layout(mode, count, rows, cols);
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DIM_W-1:0] value);
    bit taken;
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_bus.ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      REG_DISPLAY_WIDTH:  layout_w = value;
      REG_DISPLAY_HEIGHT: layout_h = value;
      default: ;
    endcase
  endtask

  task automatic set_display(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_DISPLAY_WIDTH, w);
    write_reg(REG_DISPLAY_HEIGHT, h);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick, n, rows, cols;
    pick = $urandom_range(0, 9);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
    if (pick == 0) begin
      send_request(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 127)),
                   CNT_W'($urandom_range(0, 127)), CNT_W'($urandom_range(0, 127)));
    end else if (pick <= 4) begin
      // Row and column fields carry junk that automatic mode must ignore.
      send_request(1'b0, CNT_W'(n), CNT_W'($urandom_range(0, 127)),
                   CNT_W'($urandom_range(0, 127)));
    end else if (pick <= 8) begin
      rows = $urandom_range(1, n + 2);
      cols = (n + rows - 1) / rows + $urandom_range(0, 2);
      send_request(1'b1, CNT_W'(n), CNT_W'(rows), CNT_W'(cols));
    end else begin
      n = $urandom_range(2, 64);
      rows = $urandom_range(1, n - 1);
      cols = (n - 1) / rows;
      send_request(1'b1, CNT_W'(n), CNT_W'(rows), CNT_W'(cols));
    end
  endtask

  task automatic test_reset_defaults();
    send_request(1'b0, 7'd1, 7'd0, 7'd0);
    send_request(1'b0, 7'd64, 7'd0, 7'd0);
    send_request(1'b1, 7'd7, 7'd3, 7'd3);
    wait_idle();
  endtask

  task automatic test_bad_requests();
    send_request(1'b0, 7'd0, 7'd4, 7'd4);
    send_request(1'b1, 7'd0, 7'd4, 7'd4);
    send_request(1'b0, 7'd65, 7'd0, 7'd0);
    send_request(1'b1, 7'd127, 7'd127, 7'd127);
    send_request(1'b1, 7'd3, 7'd0, 7'd5);
    send_request(1'b1, 7'd3, 7'd5, 7'd0);
    send_request(1'b1, 7'd7, 7'd2, 7'd3);
    wait_idle();
  endtask

  task automatic test_auto_grid();
    send_request(1'b0, 7'd2, 7'd0, 7'd0);
    send_request(1'b0, 7'd3, 7'd0, 7'd0);
    send_request(1'b0, 7'd5, 7'd0, 7'd0);
    send_request(1'b0, 7'd10, 7'd0, 7'd0);
    send_request(1'b0, 7'd17, 7'd0, 7'd0);
    send_request(1'b0, 7'd63, 7'd0, 7'd0);
    wait_idle();
  endtask

  task automatic test_custom_grid();
    send_request(1'b1, 7'd64, 7'd1, 7'd64);
    send_request(1'b1, 7'd64, 7'd64, 7'd1);
    send_request(1'b1, 7'd1, 7'd1, 7'd1);
    send_request(1'b1, 7'd64, 7'd127, 7'd127);
    send_request(1'b1, 7'd1, 7'd127, 7'd1);
    wait_idle();
  endtask

  // The receiver holds off while requests keep coming, so the input must stall.
  task automatic test_backpressure();
    hold_left = 400;
    steady_send = 1'b1;
    repeat (10) send_request(1'b0, CNT_W'($urandom_range(1, 8)), 7'd0, 7'd0);
    steady_send = 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    logic [DIM_W-1:0] w, h;
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0: begin w = 12'd4095; h = 12'd1;    end
        1: begin w = 12'd1;    h = 12'd4095; end
        2: begin w = 12'd0;    h = 12'd0;    end
        3: begin w = 12'd0;    h = 12'd1080; end
        4: begin w = 12'd1920; h = 12'd0;    end
        5: begin w = 12'd4095; h = 12'd4095; end
        6: begin w = 12'd1;    h = 12'd1;    end
        10: begin w = DEF_DISPLAY_WIDTH; h = DEF_DISPLAY_HEIGHT; end
        default: begin
          w = DIM_W'($urandom_range(0, 4095));
          h = DIM_W'($urandom_range(0, 4095));
        end
      endcase
      set_display(w, h);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random_request();
        // Now and then the sender stops until everything it asked for is out.
        if ($urandom_range(0, 39) == 0) begin
          req_bus.valid <= 1'b0;
          while (cells_due.size() != 0) @(posedge clk);
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    mismatches  = 0;
    beats_seen  = 0;
    hold_left   = 0;
    burst_left  = 0;
    steady_send = 1'b0;
    layout_w    = DEF_DISPLAY_WIDTH;
    layout_h    = DEF_DISPLAY_HEIGHT;
    rst_n                <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.mode         <= 1'b0;
    req_bus.stream_count <= '0;
    req_bus.grid_rows    <= '0;
    req_bus.grid_cols    <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.addr         <= REG_DISPLAY_WIDTH;
    cfg_bus.data         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_bad_requests();
    test_auto_grid();
    test_custom_grid();
    test_backpressure();
    test_random();
    wait_idle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
